FILE: hw/rtl/tnds_pkg.sv
package tnds_pkg;

    localparam int OUT_SIZE  = 32;
    localparam int OUT_IDX_W = $clog2(OUT_SIZE);
    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = 13;
    localparam int POS_W     = 12;
    localparam int PROD_W    = DIM_W + OUT_IDX_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [7:0]           DARK_LIMIT  = 8'd127;
    localparam logic [DIM_W-1:0]     DIM_RESET   = DIM_W'(OUT_SIZE);
    localparam logic [DIM_W-1:0]     DIM_MAX     = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0]     DIM_MIN     = DIM_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 1'b1;

    // one row-end emission: which output rows, and the sampled word
    typedef struct packed {
        logic                valid;
        logic [OUT_SIZE-1:0] rows;
        logic [OUT_SIZE-1:0] word;
    } t_emit_job;

    // bit k set when output index k samples source position pos,
    // i.e. floor(k*dim/OUT_SIZE) == pos
    function automatic logic [OUT_SIZE-1:0] match_mask(input logic [DIM_W-1:0] dim,
                                                        input logic [POS_W-1:0] pos);
        logic [OUT_SIZE-1:0] m;
        logic [PROD_W-1:0]   p;
        m = '0;
        for (int k = 0; k < OUT_SIZE; k++) begin
            p    = PROD_W'(dim) * PROD_W'(k);
            m[k] = (p[PROD_W-1:OUT_IDX_W] == {1'b0, pos});
        end
        return m;
    endfunction

endpackage

FILE: hw/rtl/threshold_nearest_downscale_32_top.sv
// Binarizing nearest-neighbor scaler to a 32x32 image. Source pixels (red level, dark when
// below 127) stream in raster order, one word per clock; output column j samples source
// column floor(j*W/32) and output row i samples source row floor(i*H/32). At each source
// row end every output row mapped to it leaves as one 32-bit word, lowest row first, with
// run_last on the final one. A pixel is taken every cycle except at a row end that has
// output rows while the single emission buffer is still draining the previous row end;
// the input then stalls until the emitter, which sends one row word per cycle unless the
// receiver stalls it, loads the last pending row (more than one only when height < 32).
// A row-end pixel passes the input, row-mask and output registers before its first word
// is valid. Width and height (0 acts as 1, above 4096 acts as 4096) may be written only
// while the block is idle.
module threshold_nearest_downscale_32_top
    import tnds_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_red_level,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [OUT_IDX_W-1:0] o_out_row,
    output logic [OUT_SIZE-1:0]  o_row_pixels,
    output logic                 o_run_last,
    output logic                 o_frame_done
);

    logic [DIM_W-1:0] width, height;
    logic             em_free;
    t_emit_job        job;

    tnds_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_width     (width),
        .o_height    (height)
    );

    tnds_sampler u_sampler (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_width     (width),
        .i_height    (height),
        .i_valid     (i_valid),
        .i_red_level (i_red_level),
        .o_stall     (o_stall),
        .i_em_free   (em_free),
        .o_job       (job)
    );

    tnds_emitter u_emitter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (job),
        .o_em_free    (em_free),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_row    (o_out_row),
        .o_row_pixels (o_row_pixels),
        .o_run_last   (o_run_last),
        .o_frame_done (o_frame_done)
    );

    // a new job never lands on a buffer that still holds unsent rows
    a_job_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job.valid |-> em_free)
        else $error("row-end job loaded while emitter busy");

    // row 31 is the highest row of its source row, so it always closes the run
    a_frame_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_done) |-> o_run_last)
        else $error("frame_done without run_last");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid right after reset");

endmodule

FILE: hw/rtl/tnds_cfg.sv
module tnds_cfg
    import tnds_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    output logic [DIM_W-1:0]     o_width,
    output logic [DIM_W-1:0]     o_height
);

    logic [DIM_W-1:0] r_width, r_height;
    logic [DIM_W-1:0] n_dim;

    // store the effective size: zero acts as one, oversize saturates
    always_comb begin
        if (i_cfg_data == '0)
            n_dim = DIM_MIN;
        else if (i_cfg_data > DIM_MAX)
            n_dim = DIM_MAX;
        else
            n_dim = i_cfg_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_RESET;
            r_height <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:  r_width  <= n_dim;
                CFG_SRC_HEIGHT: r_height <= n_dim;
                default: ;
            endcase
        end
    end

    assign o_width  = r_width;
    assign o_height = r_height;

endmodule

FILE: hw/rtl/tnds_sampler.sv
module tnds_sampler
    import tnds_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [DIM_W-1:0] i_width,
    input  logic [DIM_W-1:0] i_height,
    input  logic             i_valid,
    input  logic [7:0]       i_red_level,
    output logic             o_stall,
    input  logic             i_em_free,
    output t_emit_job        o_job
);

    logic                r_in_valid;
    logic [7:0]          r_red;
    logic [POS_W-1:0]    r_col, r_row;
    logic [OUT_SIZE-1:0] r_accum;

    logic                row_end, frame_end, proc_go, in_take;
    logic [OUT_SIZE-1:0] col_bits, word, rows;

    assign col_bits  = (r_red < DARK_LIMIT) ? match_mask(i_width, r_col) : '0;
    assign word      = r_accum | col_bits;
    assign row_end   = ({1'b0, r_col} + DIM_W'(1)) >= i_width;
    assign frame_end = ({1'b0, r_row} + DIM_W'(1)) >= i_height;
    assign rows      = match_mask(i_height, r_row);

    // a row end with output waits until the emitter can take the job
    assign proc_go = r_in_valid && (!row_end || rows == '0 || i_em_free);
    assign in_take = !r_in_valid || proc_go;
    assign o_stall = !in_take;

    assign o_job.valid = proc_go && row_end && rows != '0;
    assign o_job.rows  = rows;
    assign o_job.word  = word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_accum    <= '0;
        end else begin
            if (in_take)
                r_in_valid <= i_valid;
            if (proc_go) begin
                if (row_end) begin
                    r_col   <= '0;
                    r_accum <= '0;
                    r_row   <= frame_end ? '0 : r_row + POS_W'(1);
                end else begin
                    r_col   <= r_col + POS_W'(1);
                    r_accum <= word;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_valid)
            r_red <= i_red_level;
    end

endmodule

FILE: hw/rtl/tnds_emitter.sv
module tnds_emitter
    import tnds_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_emit_job            i_job,
    output logic                 o_em_free,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [OUT_IDX_W-1:0] o_out_row,
    output logic [OUT_SIZE-1:0]  o_row_pixels,
    output logic                 o_run_last,
    output logic                 o_frame_done
);

    logic [OUT_SIZE-1:0]  r_mask, r_word;
    logic                 r_o_valid;
    logic [OUT_IDX_W-1:0] r_o_row;
    logic [OUT_SIZE-1:0]  r_o_pixels;
    logic                 r_o_last, r_o_frame;

    logic [OUT_SIZE-1:0]  rest;
    logic [OUT_IDX_W-1:0] idx;
    logic                 out_load;

    // lowest pending output row goes first
    always_comb begin
        idx = '0;
        for (int k = OUT_SIZE - 1; k >= 0; k--) begin
            if (r_mask[k])
                idx = OUT_IDX_W'(k);
        end
    end

    assign rest      = r_mask & (r_mask - OUT_SIZE'(1));
    assign out_load  = (r_mask != '0) && (!r_o_valid || !i_stall);
    assign o_em_free = (r_mask == '0) || (out_load && rest == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_job.valid)
                r_mask <= i_job.rows;
            else if (out_load)
                r_mask <= rest;
            if (out_load)
                r_o_valid <= 1'b1;
            else if (!i_stall)
                r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job.valid)
            r_word <= i_job.word;
        if (out_load) begin
            r_o_row    <= idx;
            r_o_pixels <= r_word;
            r_o_last   <= (rest == '0);
            r_o_frame  <= (idx == OUT_IDX_W'(OUT_SIZE - 1));
        end
    end

    assign o_valid      = r_o_valid;
    assign o_out_row    = r_o_row;
    assign o_row_pixels = r_o_pixels;
    assign o_run_last   = r_o_last;
    assign o_frame_done = r_o_frame;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tnds_pkg::*;

    localparam int RANDOM_PIXELS = 90;
    localparam int QUIET_TAIL    = 30;   // last random pixels run without idling
    localparam int IDLE_PAD      = 8;    // row-end latency plus emission buffer
    localparam int STUCK_LIMIT   = 2000;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] out_row;
        logic [OUT_SIZE-1:0]  row_pixels;
        logic                 run_last;
        logic                 frame_done;
    } t_row_word;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_SRC_WIDTH;
    logic [DIM_W-1:0]     i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic [7:0]           i_red_level = '0;
    logic                 i_stall     = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [OUT_IDX_W-1:0] o_out_row;
    logic [OUT_SIZE-1:0]  o_row_pixels;
    logic                 o_run_last;
    logic                 o_frame_done;

    // scaler model state
    logic [DIM_W-1:0]    cfg_w     = DIM_RESET;
    logic [DIM_W-1:0]    cfg_h     = DIM_RESET;
    logic [POS_W-1:0]    col_pos   = '0;
    logic [POS_W-1:0]    row_pos   = '0;
    logic [OUT_SIZE-1:0] row_accum = '0;

    t_row_word   pending_rows[$];
    bit          idle_bursts   = 1'b1;
    int          rx_hold       = 0;
    int          stuck_cycles  = 0;
    int unsigned errors        = 0;
    int unsigned pixels_sent   = 0;
    int unsigned rows_checked  = 0;
    int unsigned settings_used = 0;

    threshold_nearest_downscale_32_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red_level  (i_red_level),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_row    (o_out_row),
        .o_row_pixels (o_row_pixels),
        .o_run_last   (o_run_last),
        .o_frame_done (o_frame_done)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned dim_in_use(input logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (v > DIM_MAX) return MAX_DIM;
        return 32'(v);
    endfunction

    // sample one pixel, and at a row end queue every output row mapped to it
    function automatic void predict_pixel(input logic [7:0] red);
        int unsigned w;
        int unsigned h;
        int unsigned last_row;
        t_row_word   word;
        w = dim_in_use(cfg_w);
        h = dim_in_use(cfg_h);
        if (red < DARK_LIMIT) begin
            for (int unsigned j = 0; j < OUT_SIZE; j++) begin
                if (((j * w) >> OUT_IDX_W) == col_pos) row_accum[j] = 1'b1;
            end
        end
        if (col_pos + 1 < w) begin
            col_pos = col_pos + 1'b1;
            return;
        end
        last_row = OUT_SIZE;
        for (int unsigned i = 0; i < OUT_SIZE; i++) begin
            if (((i * h) >> OUT_IDX_W) == row_pos) last_row = i;
        end
        for (int unsigned i = 0; i < OUT_SIZE; i++) begin
            if (((i * h) >> OUT_IDX_W) == row_pos) begin
                word.out_row    = OUT_IDX_W'(i);
                word.row_pixels = row_accum;
                word.run_last   = (i == last_row);
                word.frame_done = (i == OUT_SIZE - 1);
                pending_rows.push_back(word);
            end
        end
        col_pos   = '0;
        row_accum = '0;
        if (row_pos + 1 < h) begin
            row_pos = row_pos + 1'b1;
        end else begin
            row_pos = '0;
        end
    endfunction

    // half the draws cluster around the dark threshold
    function automatic logic [7:0] rand_red();
        if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(120, 134));
    endfunction

    task automatic send_pixel(input logic [7:0] red);
        logic accepted;
        if (idle_bursts && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_red_level <= red;
        accepted = 1'b0;
        while (!accepted) begin
            @(negedge i_clk);
            accepted = !o_stall;
            @(posedge i_clk);
        end
        predict_pixel(red);
        pixels_sent++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (IDLE_PAD) @(posedge i_clk);
    endtask

    task automatic set_size(input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SRC_WIDTH;
        i_cfg_data  <= width;
        @(posedge i_clk);
        cfg_w = width;
        i_cfg_index <= CFG_SRC_HEIGHT;
        i_cfg_data  <= height;
        @(posedge i_clk);
        cfg_h = height;
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // 32x32 after reset: a few pixels, left mid-row on purpose
    task automatic test_reset_defaults();
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd100);
        send_pixel(8'd200);
    endtask

    // 0x0 acts as 1x1: every pixel ends row and frame and emits all 32 rows;
    // the first one also closes the row left open at 32 wide
    task automatic test_zero_size();
        wait_idle();
        set_size('0, '0);
        send_pixel(8'd0);
        send_pixel(8'd126);
        send_pixel(8'd127);
        send_pixel(8'd128);
        send_pixel(8'd255);
    endtask

    // height 4: each source row fans out to 8 output rows
    task automatic test_upscale_rows();
        wait_idle();
        set_size(DIM_W'(2), DIM_W'(4));
        send_pixel(8'd10);
        send_pixel(8'd200);
        send_pixel(8'd130);
        send_pixel(8'd90);
        send_pixel(8'd126);
        send_pixel(8'd127);
        send_pixel(8'd0);
        send_pixel(8'd255);
    endtask

    // height 64: odd source rows map to no output row
    task automatic test_skipped_rows();
        wait_idle();
        set_size(DIM_W'(2), DIM_W'(64));
        for (int k = 0; k < 6; k++) send_pixel(k[0] ? 8'd250 : 8'd5);
    endtask

    // height 8191 clamps to 4096 (row 1 sits at source row 128), then a
    // short height ends the frame at the next row end
    task automatic test_oversize_height();
        wait_idle();
        set_size(DIM_W'(1), {DIM_W{1'b1}});
        for (int k = 0; k < 129; k++) send_pixel(rand_red());
        wait_idle();
        set_size(DIM_W'(1), DIM_W'(4));
        send_pixel(rand_red());
    endtask

    // width 8191 clamps to 4096; width 1 written mid-row then closes the row
    // early, and height 2 fans each source row out to 16 output rows
    task automatic test_oversize_width();
        wait_idle();
        set_size({DIM_W{1'b1}}, DIM_W'(2));
        for (int k = 0; k < 6; k++) send_pixel(rand_red());
        wait_idle();
        set_size(DIM_W'(1), DIM_W'(2));
        send_pixel(8'd0);
        send_pixel(8'd255);
    endtask

    task automatic test_random_frames();
        int unsigned w;
        int unsigned h;
        int unsigned count;
        int unsigned done;
        done = 0;
        while (done < RANDOM_PIXELS) begin
            if (done + QUIET_TAIL >= RANDOM_PIXELS) idle_bursts = 1'b0;
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 16);
            case ($urandom_range(0, 9))
                0: w = 0;
                1: h = 0;
                2: begin
                    w = $urandom_range(9, 40);
                    h = $urandom_range(0, 3);
                end
                3: h = $urandom_range(17, 40);
                default: ;
            endcase
            wait_idle();
            set_size(DIM_W'(w), DIM_W'(h));
            count = dim_in_use(DIM_W'(w)) * dim_in_use(DIM_W'(h));
            // broken frame: stop early and leave the counters mid-frame
            if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
            if (count > RANDOM_PIXELS - done) count = RANDOM_PIXELS - done;
            for (int unsigned k = 0; k < count; k++) begin
                send_pixel(rand_red());
                if ($urandom_range(0, 63) == 0) wait_idle();
            end
            done += count;
        end
    endtask

    // random receiver stall bursts while idle_bursts is set
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_stall <= 1'b1;
        end else if (idle_bursts && $urandom_range(0, 5) == 0) begin
            rx_hold <= $urandom_range(0, 4);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // sampled mid-cycle: a word seen here is taken at the next rising edge
    always @(negedge i_clk) begin : row_checker
        t_row_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_rows.size() == 0) begin
                $display("%0t: unexpected row word: out_row %0d row_pixels %h", $time,
                         o_out_row, o_row_pixels);
                errors++;
            end else begin
                want = pending_rows.pop_front();
                rows_checked++;
                if (o_out_row !== want.out_row) begin
                    $display("%0t: out_row expected %0d actual %0d", $time,
                             want.out_row, o_out_row);
                    errors++;
                end
                if (o_row_pixels !== want.row_pixels) begin
                    $display("%0t: row_pixels (row %0d) expected %h actual %h", $time,
                             want.out_row, want.row_pixels, o_row_pixels);
                    errors++;
                end
                if (o_run_last !== want.run_last) begin
                    $display("%0t: run_last (row %0d) expected %0b actual %0b", $time,
                             want.out_row, want.run_last, o_run_last);
                    errors++;
                end
                if (o_frame_done !== want.frame_done) begin
                    $display("%0t: frame_done (row %0d) expected %0b actual %0b", $time,
                             want.out_row, want.frame_done, o_frame_done);
                    errors++;
                end
            end
        end
        if ((o_valid && !i_stall) || (i_valid && !o_stall)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d rows outstanding", $time,
                     STUCK_LIMIT, pending_rows.size());
            $display("threshold_nearest_downscale_32_top test failed");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_zero_size();
        test_upscale_rows();
        test_skipped_rows();
        test_oversize_height();
        test_oversize_width();
        test_random_frames();
        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d pixels over %0d size settings: zero, clamped, upscaled, skipped rows",
                 pixels_sent, settings_used);
        $display("Checked %0d row words, %0d mismatches", rows_checked, errors);
        if (errors == 0 && pending_rows.size() == 0) begin
            $display("threshold_nearest_downscale_32_top test passed");
        end else begin
            $display("threshold_nearest_downscale_32_top test failed");
        end
        $finish;
    end

endmodule

FILE: threshold_nearest_downscale_32_top.f
hw/rtl/tnds_pkg.sv
hw/rtl/tnds_cfg.sv
hw/rtl/tnds_sampler.sv
hw/rtl/tnds_emitter.sv
hw/rtl/threshold_nearest_downscale_32_top.sv
verif/tb_top.sv
